>>> rtl/core/bopa_pkg.sv
package bopa_pkg;

    localparam int NUM_OBJECTS_DEF = 4;
    localparam int NULL_CODE_DEF   = 255;
    localparam int PRIORITY_LEVELS = 16;
    localparam int CFG_COUNT       = 4;
    localparam int ID_W            = 22;
    localparam int CFG_ADDR_W      = 2;
    localparam int SLOT_W          = 2;
    localparam int SLOT_IDX_W      = 4;
    localparam int ROW_W           = SLOT_W * PRIORITY_LEVELS;

    localparam logic [7:0] RESERVED_PRIORITY = 8'd6;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ROW_W-1:0]  t_row;

    localparam t_slot SLOT_INACTIVE = 2'd0;
    localparam t_slot SLOT_ACTIVE   = 2'd1;
    localparam t_slot SLOT_NULL     = 2'd2;
    localparam t_row  ROW_ALL_NULL  = {PRIORITY_LEVELS{SLOT_NULL}};

    localparam logic [2:0] ACT_WRITE_PV  = 3'd0;
    localparam logic [2:0] ACT_WRITE_OOS = 3'd1;
    localparam logic [2:0] ACT_READ      = 3'd2;
    localparam logic [2:0] ACT_SYNC_IN   = 3'd3;
    localparam logic [2:0] ACT_SYNC_OUT  = 3'd4;

    localparam logic [1:0] KIND_ENUM  = 2'd0;
    localparam logic [1:0] KIND_NULL  = 2'd1;
    localparam logic [1:0] KIND_BOOL  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNKNOWN_OBJ  = 3'd1;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd2;
    localparam logic [2:0] ST_DENIED       = 3'd3;
    localparam logic [2:0] ST_INVALID_TYPE = 3'd4;
    localparam logic [2:0] ST_NOT_ARRAY    = 3'd5;

    typedef struct packed {
        logic load;
        logic lookup;
        logic exec;
        logic resolve;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

endpackage

>>> rtl/core/bopa_ctrl.sv
module bopa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bopa_pkg::t_stat i_stat,
    output bopa_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_LOOKUP  = 2'd1;
    localparam logic [1:0] S_EXEC    = 2'd2;
    localparam logic [1:0] S_RESOLVE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.load    = i_valid && o_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (!i_stat.out_full) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/bopa_dp.sv
module bopa_dp #(
    parameter int NUM_OBJECTS = bopa_pkg::NUM_OBJECTS_DEF,
    parameter int NULL_CODE   = bopa_pkg::NULL_CODE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bopa_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bopa_pkg::ID_W-1:0]         i_cfg_wdata,
    input  logic [2:0]                        i_action,
    input  logic [bopa_pkg::ID_W-1:0]         i_instance_req,
    input  logic [7:0]                        i_priority_req,
    input  logic [1:0]                        i_value_kind,
    input  logic [7:0]                        i_value,
    input  logic                              i_array_index_given,
    input  logic [7:0]                        i_controller_value,
    input  bopa_pkg::t_cmd                    i_cmd,
    output bopa_pkg::t_stat                   o_stat,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic                              o_present_level,
    output logic [4:0]                        o_command_priority,
    output logic                              o_oos_flag,
    output logic                              o_drive_valid
);

    localparam int OBJ_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int PL    = bopa_pkg::PRIORITY_LEVELS;

    logic [bopa_pkg::ID_W-1:0] r_id [0:bopa_pkg::CFG_COUNT-1];
    bopa_pkg::t_row            r_rows [0:NUM_OBJECTS-1];
    logic [NUM_OBJECTS-1:0]    r_flags;

    logic [2:0]                r_action;
    logic [bopa_pkg::ID_W-1:0] r_inst;
    logic [7:0]                r_prio;
    logic [1:0]                r_kind;
    logic [7:0]                r_value;
    logic                      r_arr;
    logic [7:0]                r_cv;

    logic                      r_found;
    logic [OBJ_W-1:0]          r_obj;
    logic [2:0]                r_st;
    logic                      r_drive;

    logic                      r_out_valid;
    logic [2:0]                r_o_status;
    logic                      r_o_level;
    logic [4:0]                r_o_prio;
    logic                      r_o_oos;
    logic                      r_o_drive;

    logic                        hit;
    logic [OBJ_W-1:0]            hit_obj;
    bopa_pkg::t_row              row_cur;
    bopa_pkg::t_row              n_row;
    logic                        flag_cur;
    logic                        n_flag;
    logic [2:0]                  n_st;
    logic                        n_drive;
    logic                        prio_ok;
    logic [bopa_pkg::SLOT_IDX_W-1:0] wr_idx;
    bopa_pkg::t_slot             cv_slot;
    logic                        res_level;
    logic [4:0]                  res_prio;

    // instance lookup, lowest object wins
    always_comb begin
        hit     = 1'b0;
        hit_obj = '0;
        for (int k = NUM_OBJECTS - 1; k >= 0; k--) begin
            if (r_id[k] == r_inst) begin
                hit     = 1'b1;
                hit_obj = OBJ_W'(k);
            end
        end
    end

    assign row_cur  = r_rows[r_obj];
    assign flag_cur = r_flags[r_obj];
    assign prio_ok  = (r_prio != 8'd0) && (r_prio <= 8'(PL));
    assign wr_idx   = bopa_pkg::SLOT_IDX_W'(r_prio - 8'd1);
    assign cv_slot  = (r_cv == 8'(NULL_CODE)) ? bopa_pkg::SLOT_NULL :
                      (r_cv == 8'd0)          ? bopa_pkg::SLOT_INACTIVE :
                                                bopa_pkg::SLOT_ACTIVE;

    // action decode and slot update
    always_comb begin
        n_row   = row_cur;
        n_flag  = flag_cur;
        n_st    = bopa_pkg::ST_OK;
        n_drive = 1'b0;
        if (r_arr && (r_action == bopa_pkg::ACT_WRITE_PV ||
                      r_action == bopa_pkg::ACT_WRITE_OOS ||
                      r_action == bopa_pkg::ACT_READ)) begin
            n_st = bopa_pkg::ST_NOT_ARRAY;
        end else begin
            unique case (r_action)
                bopa_pkg::ACT_WRITE_PV: begin
                    priority if (r_kind == bopa_pkg::KIND_ENUM) begin
                        priority if (prio_ok && r_prio != bopa_pkg::RESERVED_PRIORITY
                                     && r_value <= 8'd1) begin
                            n_row[{wr_idx, 1'b0} +: bopa_pkg::SLOT_W] =
                                bopa_pkg::t_slot'(r_value);
                        end else if (r_prio == bopa_pkg::RESERVED_PRIORITY) begin
                            n_st = bopa_pkg::ST_DENIED;
                        end else begin
                            n_st = bopa_pkg::ST_OUT_OF_RANGE;
                        end
                    end else if (r_kind == bopa_pkg::KIND_NULL) begin
                        if (prio_ok) begin
                            n_row[{wr_idx, 1'b0} +: bopa_pkg::SLOT_W] = bopa_pkg::SLOT_NULL;
                        end else begin
                            n_st = bopa_pkg::ST_OUT_OF_RANGE;
                        end
                    end else begin
                        n_st = bopa_pkg::ST_INVALID_TYPE;
                    end
                end
                bopa_pkg::ACT_WRITE_OOS: begin
                    if (r_kind != bopa_pkg::KIND_BOOL) begin
                        n_st = bopa_pkg::ST_INVALID_TYPE;
                    end else begin
                        n_flag = (r_value != 8'd0);
                        // back in service: the lowest-priority slot (priority 16) follows the controller
                        if (flag_cur && !n_flag) begin
                            n_row[bopa_pkg::ROW_W-1 -: bopa_pkg::SLOT_W] = cv_slot;
                        end
                    end
                end
                bopa_pkg::ACT_READ: begin
                end
                bopa_pkg::ACT_SYNC_IN: begin
                    if (!flag_cur) begin
                        n_row[bopa_pkg::ROW_W-1 -: bopa_pkg::SLOT_W] = cv_slot;
                    end
                end
                bopa_pkg::ACT_SYNC_OUT: begin
                    n_drive = !flag_cur;
                end
                default: n_st = bopa_pkg::ST_OUT_OF_RANGE;
            endcase
        end
    end

    // priority encode, priority 1 first
    always_comb begin
        res_level = 1'b0;
        res_prio  = 5'd0;
        for (int i = PL - 1; i >= 0; i--) begin
            if (row_cur[i*bopa_pkg::SLOT_W +: bopa_pkg::SLOT_W] != bopa_pkg::SLOT_NULL) begin
                res_level = (row_cur[i*bopa_pkg::SLOT_W +: bopa_pkg::SLOT_W] ==
                             bopa_pkg::SLOT_ACTIVE);
                res_prio  = 5'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bopa_pkg::CFG_COUNT; k++) begin
                r_id[k] <= bopa_pkg::ID_W'(k);
            end
            for (int k = 0; k < NUM_OBJECTS; k++) begin
                r_rows[k] <= bopa_pkg::ROW_ALL_NULL;
            end
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_id[i_cfg_addr] <= i_cfg_wdata;
            end
            if (i_cmd.exec && r_found) begin
                r_rows[r_obj]  <= n_row;
                r_flags[r_obj] <= n_flag;
            end
            if (i_cmd.resolve) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_inst   <= i_instance_req;
            r_prio   <= i_priority_req;
            r_kind   <= i_value_kind;
            r_value  <= i_value;
            r_arr    <= i_array_index_given;
            r_cv     <= i_controller_value;
        end
        if (i_cmd.lookup) begin
            r_found <= hit;
            r_obj   <= hit_obj;
        end
        if (i_cmd.exec) begin
            r_st    <= n_st;
            r_drive <= n_drive;
        end
        if (i_cmd.resolve) begin
            if (r_found) begin
                r_o_status <= r_st;
                r_o_level  <= res_level;
                r_o_prio   <= res_prio;
                r_o_oos    <= flag_cur;
                r_o_drive  <= r_drive;
            end else begin
                r_o_status <= bopa_pkg::ST_UNKNOWN_OBJ;
                r_o_level  <= 1'b0;
                r_o_prio   <= 5'd0;
                r_o_oos    <= 1'b0;
                r_o_drive  <= 1'b0;
            end
        end
    end

    assign o_stat.out_full    = r_out_valid && !i_ready;
    assign o_valid            = r_out_valid;
    assign o_status           = r_o_status;
    assign o_present_level    = r_o_level;
    assign o_command_priority = r_o_prio;
    assign o_oos_flag         = r_o_oos;
    assign o_drive_valid      = r_o_drive;

endmodule

>>> rtl/core/binary_output_priority_array.sv
// channel  | handshake           | payload
// request  | i_valid / o_ready   | i_action .. i_controller_value, one beat per item
// result   | o_valid / i_ready   | o_status .. o_drive_valid, one beat per item
// config   | i_cfg_we            | i_cfg_addr, i_cfg_wdata, no wait
//
// an item passes these steps in the block: capture at the accepting edge, instance
// lookup, slot update, priority encode into the output register, which drives the result
// a new item is accepted only when the four-state sequencer is back in its idle state
// a stalled result holds the sequencer in its encode state; the next item
// can be accepted while the result waits
// reset is synchronous, clears all slots to null and all objects to in service
module binary_output_priority_array #(
    parameter int NUM_OBJECTS = bopa_pkg::NUM_OBJECTS_DEF,
    parameter int NULL_CODE   = bopa_pkg::NULL_CODE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bopa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bopa_pkg::ID_W-1:0]       i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_action,
    input  logic [bopa_pkg::ID_W-1:0]       i_instance_req,
    input  logic [7:0]                      i_priority_req,
    input  logic [1:0]                      i_value_kind,
    input  logic [7:0]                      i_value,
    input  logic                            i_array_index_given,
    input  logic [7:0]                      i_controller_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_status,
    output logic                            o_present_level,
    output logic [4:0]                      o_command_priority,
    output logic                            o_oos_flag,
    output logic                            o_drive_valid
);

    bopa_pkg::t_cmd  cmd;
    bopa_pkg::t_stat stat;

    bopa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bopa_dp #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .NULL_CODE   (NULL_CODE)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_action            (i_action),
        .i_instance_req      (i_instance_req),
        .i_priority_req      (i_priority_req),
        .i_value_kind        (i_value_kind),
        .i_value             (i_value),
        .i_array_index_given (i_array_index_given),
        .i_controller_value  (i_controller_value),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_present_level     (o_present_level),
        .o_command_priority  (o_command_priority),
        .o_oos_flag          (o_oos_flag),
        .o_drive_valid       (o_drive_valid)
    );

endmodule

>>> rtl/core/bopa_chk.sv
module bopa_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [2:0] o_status,
    input  logic       o_present_level,
    input  logic [4:0] o_command_priority,
    input  logic       o_oos_flag,
    input  logic       o_drive_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result beat dropped or changed under stall");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while an item is in flight");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bopa_pkg::ST_UNKNOWN_OBJ |->
            !o_present_level && o_command_priority == 5'd0 &&
            !o_oos_flag && !o_drive_valid)
        else $error("unknown object result carries state");

    a_drive_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_valid |-> o_status == bopa_pkg::ST_OK && !o_oos_flag)
        else $error("drive flagged for object out of service");

    a_prio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command_priority == 5'd0 |-> !o_present_level)
        else $error("active level with no commanding priority");

endmodule

bind binary_output_priority_array bopa_chk u_bopa_chk (.*);

>>> tb/binary_output_priority_array_checker.sv
`timescale 1ns / 1ps

module binary_output_priority_array_checker
    import bopa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ID_W-1:0]       i_cfg_wdata,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [2:0]            i_action,
    input  logic [ID_W-1:0]       i_instance_req,
    input  logic [7:0]            i_priority_req,
    input  logic [1:0]            i_value_kind,
    input  logic [7:0]            i_value,
    input  logic                  i_array_index_given,
    input  logic [7:0]            i_controller_value,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [2:0]            i_status,
    input  logic                  i_present_level,
    input  logic [4:0]            i_command_priority,
    input  logic                  i_oos_flag,
    input  logic                  i_drive_valid,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [2:0] status;
        logic       level;
        logic [4:0] prio;
        logic       oos;
        logic       drive;
    } t_outcome;

    logic [ID_W-1:0] inst_ids [CFG_COUNT];
    t_slot           slots [NUM_OBJECTS_DEF][PRIORITY_LEVELS];
    logic            oos_flags [NUM_OBJECTS_DEF];
    t_outcome        outcomes_due [$];

    function automatic t_slot controller_slot(input logic [7:0] cv);
        if (cv == 8'(NULL_CODE_DEF)) begin
            return SLOT_NULL;
        end
        return (cv == 8'd0) ? SLOT_INACTIVE : SLOT_ACTIVE;
    endfunction

    function automatic t_outcome execute_command(
        input logic [2:0]      act,
        input logic [ID_W-1:0] inst,
        input logic [7:0]      prio,
        input logic [1:0]      kind,
        input logic [7:0]      val,
        input logic            arr,
        input logic [7:0]      cv
    );
        t_outcome res;
        int       obj;
        logic     prio_ok;
        logic     was_oos;
        bit       found;
        res = '0;
        obj = -1;
        // lowest object number wins on duplicate ids
        for (int k = NUM_OBJECTS_DEF - 1; k >= 0; k--) begin
            if (inst_ids[k] == inst) begin
                obj = k;
            end
        end
        if (obj < 0) begin
            res.status = ST_UNKNOWN_OBJ;
            return res;
        end
        prio_ok = (prio >= 8'd1) && (prio <= 8'(PRIORITY_LEVELS));
        if (act > ACT_SYNC_OUT) begin
            res.status = ST_OUT_OF_RANGE;
        end else if (arr && act <= ACT_READ) begin
            res.status = ST_NOT_ARRAY;
        end else begin
            case (act)
                ACT_WRITE_PV: begin
                    if (kind == KIND_ENUM) begin
                        if (prio_ok && prio != RESERVED_PRIORITY && val <= 8'd1) begin
                            slots[obj][int'(prio) - 1] = val[0] ? SLOT_ACTIVE : SLOT_INACTIVE;
                        end else if (prio == RESERVED_PRIORITY) begin
                            res.status = ST_DENIED;
                        end else begin
                            res.status = ST_OUT_OF_RANGE;
                        end
                    end else if (kind == KIND_NULL) begin
                        if (prio_ok) begin
                            slots[obj][int'(prio) - 1] = SLOT_NULL;
                        end else begin
                            res.status = ST_OUT_OF_RANGE;
                        end
                    end else begin
                        res.status = ST_INVALID_TYPE;
                    end
                end
                ACT_WRITE_OOS: begin
                    if (kind != KIND_BOOL) begin
                        res.status = ST_INVALID_TYPE;
                    end else begin
                        was_oos = oos_flags[obj];
                        oos_flags[obj] = (val != 8'd0);
                        if (was_oos && !oos_flags[obj]) begin
                            slots[obj][PRIORITY_LEVELS - 1] = controller_slot(cv);
                        end
                    end
                end
                ACT_SYNC_IN: begin
                    if (!oos_flags[obj]) begin
                        slots[obj][PRIORITY_LEVELS - 1] = controller_slot(cv);
                    end
                end
                ACT_SYNC_OUT: begin
                    res.drive = !oos_flags[obj];
                end
                default: begin
                end
            endcase
        end
        found = 0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (!found && slots[obj][i] != SLOT_NULL) begin
                found     = 1;
                res.level = (slots[obj][i] == SLOT_ACTIVE);
                res.prio  = 5'(i + 1);
            end
        end
        res.oos = oos_flags[obj];
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            o_mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                inst_ids[k] = ID_W'(k);
            end
            for (int k = 0; k < NUM_OBJECTS_DEF; k++) begin
                oos_flags[k] = 1'b0;
                for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                    slots[k][i] = SLOT_NULL;
                end
            end
            outcomes_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                inst_ids[i_cfg_addr] = i_cfg_wdata;
            end
            // retire before capture: a result beat always belongs to an older request
            if (i_res_valid && i_res_ready) begin
                if (outcomes_due.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual status %0d",
                             $time, i_status);
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", int'(want.status), int'(i_status));
                    check_field("present_level", int'(want.level), int'(i_present_level));
                    check_field("command_priority", int'(want.prio),
                                int'(i_command_priority));
                    check_field("oos_flag", int'(want.oos), int'(i_oos_flag));
                    check_field("drive_valid", int'(want.drive), int'(i_drive_valid));
                end
            end
            if (i_req_valid && i_req_ready) begin
                outcomes_due.push_back(execute_command(i_action, i_instance_req,
                    i_priority_req, i_value_kind, i_value, i_array_index_given,
                    i_controller_value));
            end
        end
        o_pending = outcomes_due.size();
    end

endmodule

>>> tb/tb_binary_output_priority_array.sv
`timescale 1ns / 1ps

module tb_binary_output_priority_array;
    import bopa_pkg::*;

    localparam logic [2:0] ACT_UNDEFINED_LO = 3'd5;
    localparam logic [2:0] ACT_UNDEFINED_HI = 3'd7;
    localparam logic [7:0] NULL_V           = 8'(NULL_CODE_DEF);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [ID_W-1:0]       cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [2:0]            req_action     = '0;
    logic [ID_W-1:0]       req_instance   = '0;
    logic [7:0]            req_priority   = '0;
    logic [1:0]            req_kind       = '0;
    logic [7:0]            req_value      = '0;
    logic                  req_arr        = 1'b0;
    logic [7:0]            req_controller = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [2:0]            res_status;
    logic                  res_level;
    logic [4:0]            res_prio;
    logic                  res_oos;
    logic                  res_drive;
    int                    mismatches;
    int                    pending;

    logic [ID_W-1:0] ids_now [CFG_COUNT];
    bit              send_calm = 0;
    bit              recv_calm = 0;
    int              recv_hold = 0;
    bit              req_up    = 0;
    int              req_gap   = 0;

    binary_output_priority_array DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_wdata         (cfg_wdata),
        .i_valid             (req_valid),
        .o_ready             (req_ready),
        .i_action            (req_action),
        .i_instance_req      (req_instance),
        .i_priority_req      (req_priority),
        .i_value_kind        (req_kind),
        .i_value             (req_value),
        .i_array_index_given (req_arr),
        .i_controller_value  (req_controller),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_status            (res_status),
        .o_present_level     (res_level),
        .o_command_priority  (res_prio),
        .o_oos_flag          (res_oos),
        .o_drive_valid       (res_drive)
    );

    binary_output_priority_array_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_wdata         (cfg_wdata),
        .i_req_valid         (req_valid),
        .i_req_ready         (req_ready),
        .i_action            (req_action),
        .i_instance_req      (req_instance),
        .i_priority_req      (req_priority),
        .i_value_kind        (req_kind),
        .i_value             (req_value),
        .i_array_index_given (req_arr),
        .i_controller_value  (req_controller),
        .i_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .i_status            (res_status),
        .i_present_level     (res_level),
        .i_command_priority  (res_prio),
        .i_oos_flag          (res_oos),
        .i_drive_valid       (res_drive),
        .o_mismatches        (mismatches),
        .o_pending           (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : result_sink
        int stall;
        forever begin
            if (recv_hold > 0) begin
                stall     = recv_hold;
                recv_hold = 0;
            end else begin
                stall = recv_calm ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    task automatic send(
        input logic [2:0]      act,
        input logic [ID_W-1:0] inst,
        input logic [7:0]      prio,
        input logic [1:0]      kind,
        input logic [7:0]      val,
        input logic            arr,
        input logic [7:0]      cv
    );
        if (req_gap > 0) begin
            repeat (req_gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_action     <= act;
        req_instance   <= inst;
        req_priority   <= prio;
        req_kind       <= kind;
        req_value      <= val;
        req_arr        <= arr;
        req_controller <= cv;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        // valid stays up only when the next beat follows at once
        req_gap = send_calm ? 0 : $urandom_range(0, 11);
        req_up  = (req_gap == 0);
        if (!req_up) begin
            req_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        if (req_up) begin
            req_valid <= 1'b0;
            req_up = 0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ids(
        input logic [ID_W-1:0] id0,
        input logic [ID_W-1:0] id1,
        input logic [ID_W-1:0] id2,
        input logic [ID_W-1:0] id3
    );
        ids_now[0] = id0;
        ids_now[1] = id1;
        ids_now[2] = id2;
        ids_now[3] = id3;
        for (int k = 0; k < CFG_COUNT; k++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(k);
            cfg_wdata <= ids_now[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] pick_instance();
        if ($urandom_range(0, 99) < 88) begin
            return ids_now[$urandom_range(0, CFG_COUNT - 1)];
        end
        return ID_W'($urandom());
    endfunction

    task automatic send_random();
        logic [2:0] act;
        logic [7:0] prio;
        logic [7:0] val;
        logic [7:0] cv;
        logic [1:0] kind;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            act = 3'($urandom_range(ACT_UNDEFINED_LO, ACT_UNDEFINED_HI));
        end else if (pick < 38) begin
            act = ACT_WRITE_PV;
        end else if (pick < 53) begin
            act = ACT_WRITE_OOS;
        end else if (pick < 70) begin
            act = ACT_READ;
        end else if (pick < 85) begin
            act = ACT_SYNC_IN;
        end else begin
            act = ACT_SYNC_OUT;
        end
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
            prio = 8'($urandom_range(1, PRIORITY_LEVELS));
        end else if (pick < 88) begin
            prio = 8'd0;
        end else if (pick < 94) begin
            prio = 8'(PRIORITY_LEVELS + 1);
        end else begin
            prio = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 99);
        if (act == ACT_WRITE_PV) begin
            kind = (pick < 55) ? KIND_ENUM : (pick < 88) ? KIND_NULL : 2'($urandom_range(0, 3));
        end else if (act == ACT_WRITE_OOS) begin
            kind = (pick < 85) ? KIND_BOOL : 2'($urandom_range(0, 3));
        end else begin
            kind = 2'($urandom_range(0, 3));
        end
        val = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: cv = 8'd0;
            1: cv = 8'd1;
            2: cv = NULL_V;
            default: cv = 8'($urandom_range(0, 255));
        endcase
        send(act, pick_instance(), prio, kind, val, $urandom_range(0, 15) == 0, cv);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            send_random();
        end
        send_calm = 0;
        recv_calm = 0;
    endtask

    initial begin
        for (int k = 0; k < CFG_COUNT; k++) begin
            ids_now[k] = ID_W'(k);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed corners with reset ids
        send(ACT_READ,      22'd0, 8'd1,   KIND_ENUM,  8'd0,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, 8'd16,  KIND_ENUM,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, 8'd1,   KIND_ENUM,  8'd0,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, RESERVED_PRIORITY, KIND_ENUM, 8'd1, 1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, RESERVED_PRIORITY, KIND_NULL, 8'd0, 1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, 8'd0,   KIND_ENUM,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd0, 8'd17,  KIND_NULL,  8'd0,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd1, 8'd255, KIND_ENUM,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd1, 8'd3,   KIND_ENUM,  8'd2,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd1, 8'd8,   KIND_ENUM,  8'd255, 1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd1, 8'd8,   KIND_BOOL,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd1, 8'd8,   KIND_OTHER, 8'd0,   1'b0, 8'd0);
        send(ACT_WRITE_PV,  22'd2, 8'd4,   KIND_ENUM,  8'd1,   1'b1, 8'd0);
        send(ACT_READ,      22'd2, 8'd0,   KIND_ENUM,  8'd0,   1'b1, 8'd0);
        send(ACT_WRITE_OOS, 22'd2, 8'd0,   KIND_ENUM,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_OOS, 22'd2, 8'd0,   KIND_BOOL,  8'd255, 1'b0, 8'd0);
        send(ACT_SYNC_IN,   22'd2, 8'd0,   KIND_ENUM,  8'd0,   1'b0, 8'd1);
        send(ACT_SYNC_OUT,  22'd2, 8'd0,   KIND_ENUM,  8'd0,   1'b0, 8'd1);
        send(ACT_WRITE_OOS, 22'd2, 8'd0,   KIND_BOOL,  8'd0,   1'b0, 8'h80);
        send(ACT_SYNC_IN,   22'd3, 8'd0,   KIND_NULL,  8'd0,   1'b1, 8'd0);
        send(ACT_SYNC_OUT,  22'd3, 8'd255, KIND_OTHER, 8'd255, 1'b1, NULL_V);
        send(ACT_SYNC_IN,   22'd3, 8'd0,   KIND_ENUM,  8'd0,   1'b0, NULL_V);
        send(ACT_WRITE_PV,  22'd0, 8'd1,   KIND_NULL,  8'd0,   1'b0, 8'd0);
        send(ACT_UNDEFINED_LO, 22'd0, 8'd1, KIND_ENUM, 8'd0,   1'b0, 8'd0);
        send(ACT_UNDEFINED_HI, 22'd1, 8'd1, KIND_ENUM, 8'd0,   1'b1, 8'd0);
        send(ACT_READ,      22'h3FFFFF, 8'd1, KIND_ENUM, 8'd0, 1'b0, 8'd0);
        send(ACT_WRITE_OOS, 22'd1, 8'd0,   KIND_BOOL,  8'd1,   1'b0, 8'd0);
        send(ACT_WRITE_OOS, 22'd1, 8'd0,   KIND_BOOL,  8'd0,   1'b0, 8'd0);
        drain_results();

        write_ids(22'h3FFFFF, 22'h000000, 22'h155555, 22'h2AAAAA);
        run_random(300);
        drain_results();

        // long receiver hold while requests keep coming
        recv_hold = 250;
        send_calm = 1;
        repeat (24) send_random();
        send_calm = 0;
        drain_results();

        write_ids(22'd5, 22'd5, 22'h3FFFFF, 22'd1);
        run_random(300);
        drain_results();

        write_ids(ID_W'($urandom()), ID_W'($urandom()), ID_W'($urandom()), ID_W'($urandom()));
        run_random(300);
        drain_results();

        write_ids(22'd0, 22'd1, 22'd2, 22'd3);
        run_random(300);
        drain_results();

        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
